### hw/rtl/soi_pkg.sv
package soi_pkg;

	typedef enum logic [1:0] {
		FN_APPEND_COND  = 2'd0,
		FN_APPEND_FORCE = 2'd1,
		FN_LOOKUP       = 2'd2,
		FN_TRUNCATE     = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_ORDER    = 3'd1,
		STS_INTERVAL = 3'd2,
		STS_FULL     = 3'd3,
		STS_NOTFOUND = 3'd4,
		STS_TRUNC    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APP_CHK,
		ST_SRCH,
		ST_CMP,
		ST_FETCH,
		ST_EMIT
	} state_t;

	localparam int unsigned CNT_OUT_W     = 11;
	localparam logic [31:0] MIN_INTERVAL_RST = 32'd4096;

	typedef struct packed {
		func_t       func;
		logic [31:0] rec_offset;
		logic [31:0] byte_pos;
	} in_word_t;

	typedef struct packed {
		status_t                status;
		logic [31:0]            entry_offset;
		logic [31:0]            entry_pos;
		logic [CNT_OUT_W-1:0]   entry_count;
	} out_word_t;

endpackage

### hw/rtl/soi_store.sv
// Entry store: offset and position arrays sharing one address, one access a cycle.
// The read data is registered, so it is valid in the cycle after the address.
module soi_store #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [31:0]   wr_offset,
	input  logic [31:0]   wr_pos,
	output logic [31:0]   rd_offset,
	output logic [31:0]   rd_pos
);

	logic [31:0] offset_mem [DEPTH];
	logic [31:0] pos_mem    [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			offset_mem[addr] <= wr_offset;
			pos_mem[addr]    <= wr_pos;
		end
	end

	always_ff @(posedge clk) begin
		rd_offset <= offset_mem[addr];
		rd_pos    <= pos_mem[addr];
	end

endmodule

### hw/rtl/sparse_offset_index.sv
// Channel   Direction  Payload                 Handshake
// in        input      soi_pkg::in_word_t      in_valid / in_stall
// out       output     soi_pkg::out_word_t     out_valid / out_stall
// cfg       input      min_interval (32 bit)   cfg_we / cfg_data
//
// An append passes through the idle state that reads the last entry, the check-and-write
// state and the emit state that loads the output register.
// A lookup or truncate runs a binary search, one search and one compare state per probe on
// the single store port; a lookup hit adds a fetch state that reads the entry found.
// Reset clears the fill count, control state and output valid and sets the interval to
// 4096; the store is not cleared. Only the final hand-off waits for the output slot.
module sparse_offset_index #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  soi_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output soi_pkg::out_word_t out_word,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_data
);

	// Count width holds DEPTH itself; address width indexes DEPTH entries.
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	soi_pkg::state_t    state_q, state_d;
	soi_pkg::in_word_t  req_q, req_d;
	soi_pkg::out_word_t res_q, res_d;
	soi_pkg::out_word_t out_word_q;
	logic               out_valid_q;
	logic               out_load;

	logic [CW-1:0] fill_count_q, cnt_d;
	logic [CW-1:0] lo_q, lo_d;
	logic [CW-1:0] hi_q, hi_d;
	logic [CW-1:0] mid;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] lo_m1;
	logic [31:0]   min_interval_q;

	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [31:0]   rd_offset;
	logic [31:0]   rd_pos;
	logic          has_last;
	logic          go_right;
	logic [31:0]   pos_gap;

	soi_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk       (clk),
		.we        (mem_we),
		.addr      (mem_addr),
		.wr_offset (req_q.rec_offset),
		.wr_pos    (req_q.byte_pos),
		.rd_offset (rd_offset),
		.rd_pos    (rd_pos)
	);

	// Writes and reads never share a cycle, and a read issued after a write
	// sees the new data through the array, so no forwarding is needed.
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign cnt_m1   = fill_count_q - CW'(1);
	assign lo_m1    = lo_q - CW'(1);
	assign has_last = (fill_count_q != '0);
	assign pos_gap  = req_q.byte_pos - rd_pos;

	// The search goes right while the probed entry still belongs to the kept
	// prefix: offset at or below the target, or position below the cut.
	assign go_right = (req_q.func == soi_pkg::FN_LOOKUP) ?
		(rd_offset <= req_q.rec_offset) : (rd_pos < req_q.byte_pos);

	assign in_stall  = (state_q != soi_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	always_comb begin
		state_d  = state_q;
		req_d    = req_q;
		res_d    = res_q;
		cnt_d    = fill_count_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		mem_we   = 1'b0;
		mem_addr = mid[AW-1:0];
		out_load = 1'b0;
		unique case (state_q)
			soi_pkg::ST_IDLE: begin
				// Fetch the last entry early; appends need it next cycle.
				mem_addr = cnt_m1[AW-1:0];
				if (in_valid) begin
					req_d = in_word;
					lo_d  = '0;
					hi_d  = fill_count_q;
					unique case (in_word.func)
						soi_pkg::FN_APPEND_COND,
						soi_pkg::FN_APPEND_FORCE: state_d = soi_pkg::ST_APP_CHK;
						soi_pkg::FN_LOOKUP,
						soi_pkg::FN_TRUNCATE:     state_d = soi_pkg::ST_SRCH;
					endcase
				end
			end
			soi_pkg::ST_APP_CHK: begin
				res_d.entry_offset = '0;
				res_d.entry_pos    = '0;
				priority if (has_last && (req_q.rec_offset <= rd_offset ||
						req_q.byte_pos <= rd_pos)) begin
					res_d.status = soi_pkg::STS_ORDER;
				end else if (has_last && req_q.func == soi_pkg::FN_APPEND_COND &&
						pos_gap < min_interval_q) begin
					res_d.status = soi_pkg::STS_INTERVAL;
				end else if (fill_count_q >= FULL_CNT) begin
					res_d.status = soi_pkg::STS_FULL;
				end else begin
					res_d.status = soi_pkg::STS_OK;
					mem_we       = 1'b1;
					mem_addr     = fill_count_q[AW-1:0];
					cnt_d        = fill_count_q + CW'(1);
				end
				res_d.entry_count = soi_pkg::CNT_OUT_W'(cnt_d);
				state_d = soi_pkg::ST_EMIT;
			end
			soi_pkg::ST_SRCH: begin
				res_d.entry_offset = '0;
				res_d.entry_pos    = '0;
				res_d.status       = soi_pkg::STS_OK;
				res_d.entry_count  = soi_pkg::CNT_OUT_W'(fill_count_q);
				if (lo_q < hi_q) begin
					state_d = soi_pkg::ST_CMP;
				end else if (req_q.func == soi_pkg::FN_LOOKUP) begin
					if (lo_q == '0) begin
						res_d.status = soi_pkg::STS_NOTFOUND;
						state_d      = soi_pkg::ST_EMIT;
					end else begin
						mem_addr = lo_m1[AW-1:0];
						state_d  = soi_pkg::ST_FETCH;
					end
				end else begin
					if (lo_q < fill_count_q) begin
						cnt_d             = lo_q;
						res_d.status      = soi_pkg::STS_TRUNC;
						res_d.entry_count = soi_pkg::CNT_OUT_W'(lo_q);
					end
					state_d = soi_pkg::ST_EMIT;
				end
			end
			soi_pkg::ST_CMP: begin
				if (go_right) begin
					lo_d = mid + CW'(1);
				end else begin
					hi_d = mid;
				end
				state_d = soi_pkg::ST_SRCH;
			end
			soi_pkg::ST_FETCH: begin
				res_d.entry_offset = rd_offset;
				res_d.entry_pos    = rd_pos;
				state_d            = soi_pkg::ST_EMIT;
			end
			soi_pkg::ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = soi_pkg::ST_IDLE;
				end
			end
			default: state_d = soi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= soi_pkg::ST_IDLE;
			fill_count_q   <= '0;
			out_valid_q    <= 1'b0;
			min_interval_q <= soi_pkg::MIN_INTERVAL_RST;
		end else begin
			state_q      <= state_d;
			fill_count_q <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				min_interval_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_q <= req_d;
		res_q <= res_d;
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		if (out_load) begin
			out_word_q <= res_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= FULL_CNT)
		else $error("fill count above table depth");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == soi_pkg::ST_APP_CHK && fill_count_q < FULL_CNT))
		else $error("store write outside an append with room");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == soi_pkg::ST_SRCH || state_q == soi_pkg::ST_CMP) |->
		(lo_q <= hi_q && hi_q <= fill_count_q))
		else $error("binary search window out of order");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == soi_pkg::ST_IDLE || state_q == soi_pkg::ST_CMP ||
		 state_q == soi_pkg::ST_FETCH || state_q == soi_pkg::ST_EMIT)
		|=> $stable(fill_count_q))
		else $error("fill count changed outside append or truncate");

endmodule

### bench/tb_sparse_offset_index.sv
module tb_sparse_offset_index;

	localparam int unsigned TBL_DEPTH = 1024;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	soi_pkg::in_word_t  in_word;
	logic               out_valid;
	logic               out_stall;
	soi_pkg::out_word_t out_word;
	logic               cfg_we;
	logic [31:0]        cfg_data;

	sparse_offset_index #(
		.DEPTH(TBL_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the index table, its fill level and the interval register.
	// These are updated in acceptance order, so they always describe the table as the
	// block sees it when it starts on the next word.
	logic [31:0] idx_off [TBL_DEPTH];
	logic [31:0] idx_pos [TBL_DEPTH];
	int unsigned idx_fill;
	logic [31:0] gap_min;

	// Result words owed by the block, oldest first.
	soi_pkg::out_word_t due_results [$];
	soi_pkg::out_word_t head_w;
	int unsigned        mismatch_cnt;

	// Chance, in percent, that a burst of idle cycles starts on each side.
	int unsigned in_gap_pct;
	int unsigned out_gap_pct;

	// One row of the directed sequence. Where typed is set, want is the result read
	// straight off the rules; otherwise the shadow table decides what is owed.
	typedef struct {
		soi_pkg::func_t     fn;
		logic [31:0]        arg_off;
		logic [31:0]        arg_pos;
		bit                 typed;
		soi_pkg::out_word_t want;
	} dir_row_t;

	// The directed part runs with the interval register at its reset value of 4096.
	dir_row_t dir_plan [23] = '{
		// Empty table: a lookup misses, a truncate removes nothing.
		'{soi_pkg::FN_LOOKUP,       32'd0,          32'd0,          1'b1,
			'{soi_pkg::STS_NOTFOUND, 32'd0, 32'd0, 11'd0}},
		'{soi_pkg::FN_TRUNCATE,     32'd0,          32'd0,          1'b1,
			'{soi_pkg::STS_OK, 32'd0, 32'd0, 11'd0}},
		// Any pair goes into an empty table, even the all-zero one.
		'{soi_pkg::FN_APPEND_COND,  32'd0,          32'd0,          1'b1,
			'{soi_pkg::STS_OK, 32'd0, 32'd0, 11'd1}},
		// Offset not past the last entry.
		'{soi_pkg::FN_APPEND_COND,  32'd0,          32'd5000,       1'b1,
			'{soi_pkg::STS_ORDER, 32'd0, 32'd0, 11'd1}},
		// Ordered, but the position moved less than the interval.
		'{soi_pkg::FN_APPEND_COND,  32'd10,         32'd100,        1'b1,
			'{soi_pkg::STS_INTERVAL, 32'd0, 32'd0, 11'd1}},
		// Exactly the interval is enough.
		'{soi_pkg::FN_APPEND_COND,  32'd10,         32'd4096,       1'b1,
			'{soi_pkg::STS_OK, 32'd0, 32'd0, 11'd2}},
		// A forced append ignores the interval but not the ordering.
		'{soi_pkg::FN_APPEND_FORCE, 32'd20,         32'd4097,       1'b1,
			'{soi_pkg::STS_OK, 32'd0, 32'd0, 11'd3}},
		'{soi_pkg::FN_APPEND_FORCE, 32'd20,         32'd5000,       1'b1,
			'{soi_pkg::STS_ORDER, 32'd0, 32'd0, 11'd3}},
		// Lookups between entries, past the end and on the first entry.
		'{soi_pkg::FN_LOOKUP,       32'd15,         32'hFFFF_FFFF,  1'b1,
			'{soi_pkg::STS_OK, 32'd10, 32'd4096, 11'd3}},
		'{soi_pkg::FN_LOOKUP,       32'hFFFF_FFFF,  32'd0,          1'b1,
			'{soi_pkg::STS_OK, 32'd20, 32'd4097, 11'd3}},
		'{soi_pkg::FN_LOOKUP,       32'd0,          32'd7,          1'b1,
			'{soi_pkg::STS_OK, 32'd0, 32'd0, 11'd3}},
		'{soi_pkg::FN_APPEND_FORCE, 32'h7FFF_FFFF,  32'h8000_0000,  1'b0, '0},
		'{soi_pkg::FN_APPEND_COND,  32'h8000_0000,  32'h8000_0FFF,  1'b0, '0},
		// Largest values in both fields, then nothing can follow them.
		'{soi_pkg::FN_APPEND_FORCE, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1,
			'{soi_pkg::STS_OK, 32'd0, 32'd0, 11'd5}},
		'{soi_pkg::FN_APPEND_COND,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1,
			'{soi_pkg::STS_ORDER, 32'd0, 32'd0, 11'd5}},
		'{soi_pkg::FN_LOOKUP,       32'h7FFF_FFFF,  32'h1234_5678,  1'b0, '0},
		'{soi_pkg::FN_TRUNCATE,     32'hDEAD_BEEF,  32'h8000_0000,  1'b0, '0},
		// Truncating at zero empties the table; a second truncate finds nothing.
		'{soi_pkg::FN_TRUNCATE,     32'd0,          32'd0,          1'b1,
			'{soi_pkg::STS_TRUNC, 32'd0, 32'd0, 11'd0}},
		'{soi_pkg::FN_TRUNCATE,     32'd0,          32'hFFFF_FFFF,  1'b1,
			'{soi_pkg::STS_OK, 32'd0, 32'd0, 11'd0}},
		'{soi_pkg::FN_LOOKUP,       32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1,
			'{soi_pkg::STS_NOTFOUND, 32'd0, 32'd0, 11'd0}},
		'{soi_pkg::FN_APPEND_FORCE, 32'hFFFF_FFFF,  32'd0,          1'b1,
			'{soi_pkg::STS_OK, 32'd0, 32'd0, 11'd1}},
		'{soi_pkg::FN_LOOKUP,       32'hFFFF_FFFE,  32'd0,          1'b1,
			'{soi_pkg::STS_NOTFOUND, 32'd0, 32'd0, 11'd1}},
		'{soi_pkg::FN_TRUNCATE,     32'd0,          32'd1,          1'b0, '0}
	};

	// Applies one accepted word to the shadow table and returns the result it owes.
	function automatic soi_pkg::out_word_t index_update(input soi_pkg::in_word_t w);
		soi_pkg::out_word_t r;
		int unsigned        lo;
		int unsigned        hi;
		int unsigned        mid;
		r = '0;
		r.status = soi_pkg::STS_OK;
		case (w.func)
			soi_pkg::FN_APPEND_COND, soi_pkg::FN_APPEND_FORCE: begin
				// Ordering and interval are judged before the table is found full.
				if (idx_fill != 0 && (w.rec_offset <= idx_off[idx_fill-1] ||
						w.byte_pos <= idx_pos[idx_fill-1])) begin
					r.status = soi_pkg::STS_ORDER;
				end else if (idx_fill != 0 && w.func == soi_pkg::FN_APPEND_COND &&
						w.byte_pos - idx_pos[idx_fill-1] < gap_min) begin
					r.status = soi_pkg::STS_INTERVAL;
				end else if (idx_fill >= TBL_DEPTH) begin
					r.status = soi_pkg::STS_FULL;
				end else begin
					idx_off[idx_fill] = w.rec_offset;
					idx_pos[idx_fill] = w.byte_pos;
					idx_fill++;
				end
			end
			soi_pkg::FN_LOOKUP: begin
				// Count the entries whose offset is at or below the target.
				lo = 0;
				hi = idx_fill;
				while (lo < hi) begin
					mid = (lo + hi) / 2;
					if (idx_off[mid] <= w.rec_offset)
						lo = mid + 1;
					else
						hi = mid;
				end
				if (lo == 0) begin
					r.status = soi_pkg::STS_NOTFOUND;
				end else begin
					r.entry_offset = idx_off[lo-1];
					r.entry_pos    = idx_pos[lo-1];
				end
			end
			default: begin
				// Keep only the entries whose position is below the cut.
				lo = 0;
				hi = idx_fill;
				while (lo < hi) begin
					mid = (lo + hi) / 2;
					if (idx_pos[mid] < w.byte_pos)
						lo = mid + 1;
					else
						hi = mid;
				end
				if (lo < idx_fill) begin
					idx_fill = lo;
					r.status = soi_pkg::STS_TRUNC;
				end
			end
		endcase
		r.entry_count = idx_fill[soi_pkg::CNT_OUT_W-1:0];
		return r;
	endfunction

	function automatic soi_pkg::in_word_t mk_word(input soi_pkg::func_t fn,
			input logic [31:0] off, input logic [31:0] pos);
		soi_pkg::in_word_t w;
		w.func       = fn;
		w.rec_offset = off;
		w.byte_pos   = pos;
		return w;
	endfunction

	// Random word. Most appends extend the table in order with a position step that
	// usually meets the interval, so the table grows and lookups and truncates land
	// on real entries; the rest is unconstrained noise.
	function automatic soi_pkg::in_word_t pick_word();
		soi_pkg::in_word_t w;
		logic [31:0]       last_o;
		logic [31:0]       last_p;
		int unsigned       sel;
		int unsigned       k;
		last_o = (idx_fill != 0) ? idx_off[idx_fill-1] : 32'd0;
		last_p = (idx_fill != 0) ? idx_pos[idx_fill-1] : 32'd0;
		w.rec_offset = $urandom;
		w.byte_pos   = $urandom;
		w.func       = $urandom_range(0, 1) ? soi_pkg::FN_APPEND_FORCE :
			soi_pkg::FN_APPEND_COND;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			if (idx_fill == 0) begin
				if ($urandom_range(0, 3) != 0) begin
					w.rec_offset = $urandom_range(0, 4096);
					w.byte_pos   = $urandom_range(0, 4096);
				end
			end else begin
				w.rec_offset = last_o + (($urandom_range(0, 4) != 0) ?
					$urandom_range(1, 2000) : $urandom);
				k = $urandom_range(0, 9);
				if (k < 6)
					w.byte_pos = last_p + gap_min + $urandom_range(0, 300);
				else if (k < 8)
					w.byte_pos = last_p + $urandom_range(1, 300);
				else
					w.byte_pos = last_p + $urandom;
			end
		end else if (sel < 85) begin
			w.func = soi_pkg::FN_LOOKUP;
			if (idx_fill != 0 && $urandom_range(0, 1) != 0)
				w.rec_offset = idx_off[$urandom_range(0, idx_fill-1)] +
					$urandom_range(0, 2) - 1;
		end else if (sel >= 55) begin
			w.func = soi_pkg::FN_TRUNCATE;
			if (idx_fill != 0 && $urandom_range(0, 2) != 0)
				w.byte_pos = idx_pos[$urandom_range(0, idx_fill-1)] +
					$urandom_range(0, 1);
		end
		return w;
	endfunction

	// Presents one word, holds it until the block takes it, then books the result.
	// Valid stays high after acceptance so back-to-back words need no extra edge.
	task automatic send_word(input soi_pkg::in_word_t w, input bit typed,
			input soi_pkg::out_word_t want);
		soi_pkg::out_word_t guess;
		int unsigned        n;
		if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
			n = $urandom_range(1, 7);
			@(negedge clk) in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		guess = index_update(w);
		due_results.insert(due_results.size(), typed ? want : guess);
	endtask

	// Drops valid and waits for every owed result plus the append latency, so the
	// block is idle before the interval register is touched.
	task automatic settle();
		@(negedge clk) in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_min_gap(input logic [31:0] v);
		settle();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk) cfg_we <= 1'b0;
		gap_min = v;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Consumer stalls come in bursts.
	initial begin : stall_gen
		int unsigned n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (out_gap_pct != 0 && $urandom_range(0, 99) < out_gap_pct) begin
				n = $urandom_range(1, 7);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Every result word handed over is matched against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$error("result word with nothing owed: %h", out_word);
				mismatch_cnt++;
			end else begin
				head_w = due_results.pop_front();
				if (out_word.status != head_w.status) begin
					$error("status: expected %0d, got %0d", head_w.status, out_word.status);
					mismatch_cnt++;
				end
				if (out_word.entry_offset != head_w.entry_offset) begin
					$error("entry_offset: expected %h, got %h", head_w.entry_offset,
						out_word.entry_offset);
					mismatch_cnt++;
				end
				if (out_word.entry_pos != head_w.entry_pos) begin
					$error("entry_pos: expected %h, got %h", head_w.entry_pos,
						out_word.entry_pos);
					mismatch_cnt++;
				end
				if (out_word.entry_count != head_w.entry_count) begin
					$error("entry_count: expected %0d, got %0d", head_w.entry_count,
						out_word.entry_count);
					mismatch_cnt++;
				end
			end
		end
	end

	// Hard stop, far beyond the slowest correct run.
	initial begin
		#(20 * 400000);
		$display("Mismatches found");
		$finish;
	end

	initial begin : main
		logic [31:0] phase_gap [6];
		int unsigned phase_idle [6];
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_word      = '0;
		cfg_we       = 1'b0;
		cfg_data     = '0;
		idx_fill     = 0;
		gap_min      = soi_pkg::MIN_INTERVAL_RST;
		mismatch_cnt = 0;
		in_gap_pct   = 30;
		out_gap_pct  = 30;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed sequence, interval at its reset value.
		foreach (dir_plan[i])
			send_word(mk_word(dir_plan[i].fn, dir_plan[i].arg_off, dir_plan[i].arg_pos),
				dir_plan[i].typed, dir_plan[i].want);

		// Full table. With a zero interval every ordered append goes in, so the table
		// is filled with small steps and little idling to keep the run short.
		set_min_gap(32'd0);
		in_gap_pct  = 5;
		out_gap_pct = 5;
		send_word(mk_word(soi_pkg::FN_TRUNCATE, $urandom, 32'd0), 1'b0, '0);
		while (idx_fill < TBL_DEPTH)
			send_word(mk_word($urandom_range(0, 1) ? soi_pkg::FN_APPEND_FORCE :
				soi_pkg::FN_APPEND_COND,
				((idx_fill != 0) ? idx_off[idx_fill-1] : 32'd0) + $urandom_range(1, 1000),
				((idx_fill != 0) ? idx_pos[idx_fill-1] : 32'd0) + $urandom_range(1, 1000)),
				1'b0, '0);
		in_gap_pct  = 25;
		out_gap_pct = 25;
		// A well-ordered pair is dropped as full; a badly ordered one still reports
		// the ordering.
		send_word(mk_word(soi_pkg::FN_APPEND_COND, idx_off[idx_fill-1] + 1,
			idx_pos[idx_fill-1] + 1), 1'b0, '0);
		send_word(mk_word(soi_pkg::FN_APPEND_FORCE, idx_off[idx_fill-1] + 1,
			32'hFFFF_FFFF), 1'b0, '0);
		send_word(mk_word(soi_pkg::FN_APPEND_FORCE, 32'd0, 32'hFFFF_FFFF), 1'b0, '0);
		repeat (20) send_word(mk_word(soi_pkg::FN_LOOKUP,
			$urandom_range(0, 1) ? $urandom_range(0, 1100000) : $urandom, $urandom),
			1'b0, '0);
		// With the widest interval the interval check wins over the full check.
		set_min_gap(32'hFFFF_FFFF);
		send_word(mk_word(soi_pkg::FN_APPEND_COND, idx_off[idx_fill-1] + 1,
			idx_pos[idx_fill-1] + 1), 1'b0, '0);
		send_word(mk_word(soi_pkg::FN_TRUNCATE, $urandom,
			idx_pos[$urandom_range(0, TBL_DEPTH-1)]), 1'b0, '0);

		// Random phases, each under its own interval and idling mix; the last one
		// runs with no idling on either side.
		phase_gap  = '{32'd0, 32'd1, $urandom_range(2, 65535), 32'hFFFF_FFFF, $urandom,
			soi_pkg::MIN_INTERVAL_RST};
		phase_idle = '{30, 0, 50, 20, 40, 0};
		for (int p = 0; p < 6; p++) begin
			set_min_gap(phase_gap[p]);
			in_gap_pct  = phase_idle[p];
			out_gap_pct = phase_idle[(p + 2) % 6];
			if (p == 5)
				out_gap_pct = 0;
			repeat (85) send_word(pick_word(), 1'b0, '0);
		end

		settle();
		repeat (30) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
